// ----- hdl/gba_pkg.sv -----
// Shared constants and types for the gated block averager.
// Used by gba_accum, gba_div and gated_block_averager_core.
`default_nettype none

package gba_pkg;

  // Result width: unsigned Q10.6 mean
  localparam int MEAN_W = 16;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_LO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_HI  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLK_LEN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VLD = 2'd3;

  // Register reset values
  localparam int WIN_LO_RST  = 509;
  localparam int WIN_HI_RST  = 974;
  localparam int BLK_LEN_RST = 1000;
  localparam int MIN_VLD_RST = 900;

  // Block-end report from the accumulator
  typedef struct packed {
    logic done;   // this request closes the block
    logic held;   // too few accepted samples, repeat last mean
  } blk_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/gba_accum.sv -----
// Window gate, running sum and counters, configuration registers.
// Depends on gba_pkg.
`default_nettype none

module gba_accum #(
  parameter int SAMPLE_BITS = 10,
  parameter int COUNT_BITS  = 12,
  parameter int CFG_W       = 12
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [gba_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [CFG_W-1:0]                 cfg_data_i,
  input  wire logic                             take_i,
  input  wire logic [SAMPLE_BITS-1:0]           sample_i,
  output logic      [SAMPLE_BITS+COUNT_BITS-1:0] sum_o,
  output logic      [COUNT_BITS-1:0]            acc_o,
  output gba_pkg::blk_ctrl_t                    ctrl_o
);

  localparam int SUM_W = SAMPLE_BITS + COUNT_BITS;

  logic [SAMPLE_BITS-1:0] win_lo_q, win_hi_q;
  logic [COUNT_BITS-1:0]  blk_len_q, min_vld_q;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [COUNT_BITS-1:0]  acc_q, acc_d, cnt_q, cnt_d, len;
  logic                   in_win, blk_end;

  assign in_win  = (sample_i >= win_lo_q) && (sample_i <= win_hi_q);
  assign sum_d   = in_win ? sum_q + SUM_W'(sample_i) : sum_q;
  assign acc_d   = in_win ? acc_q + COUNT_BITS'(1) : acc_q;
  assign cnt_d   = cnt_q + COUNT_BITS'(1);
  // zero length behaves as one
  assign len     = (blk_len_q == '0) ? COUNT_BITS'(1) : blk_len_q;
  assign blk_end = (cnt_d >= len);

  assign sum_o       = sum_d;
  assign acc_o       = acc_d;
  assign ctrl_o.done = take_i && blk_end;
  assign ctrl_o.held = (acc_d == '0) || (acc_d < min_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_lo_q  <= SAMPLE_BITS'(gba_pkg::WIN_LO_RST);
      win_hi_q  <= SAMPLE_BITS'(gba_pkg::WIN_HI_RST);
      blk_len_q <= COUNT_BITS'(gba_pkg::BLK_LEN_RST);
      min_vld_q <= COUNT_BITS'(gba_pkg::MIN_VLD_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gba_pkg::REG_WIN_LO:  win_lo_q  <= cfg_data_i[SAMPLE_BITS-1:0];
        gba_pkg::REG_WIN_HI:  win_hi_q  <= cfg_data_i[SAMPLE_BITS-1:0];
        gba_pkg::REG_BLK_LEN: blk_len_q <= cfg_data_i[COUNT_BITS-1:0];
        gba_pkg::REG_MIN_VLD: min_vld_q <= cfg_data_i[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      acc_q <= '0;
      cnt_q <= '0;
    end else if (take_i) begin
      if (blk_end) begin
        sum_q <= '0;
        acc_q <= '0;
        cnt_q <= '0;
      end else begin
        sum_q <= sum_d;
        acc_q <= acc_d;
        cnt_q <= cnt_d;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/gba_div.sv -----
// Bit-serial restoring divider: (sum << FRAC_BITS) / count, saturated to 16 bits.
// One quotient bit per cycle. Depends on gba_pkg.
`default_nettype none

module gba_div #(
  parameter int SUM_W      = 22,
  parameter int COUNT_BITS = 12,
  parameter int FRAC_BITS  = 6
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [SUM_W-1:0]           sum_i,
  input  wire logic [COUNT_BITS-1:0]      dvs_i,
  output logic                            done_o,
  output logic [gba_pkg::MEAN_W-1:0]      quot_o
);

  localparam int DVD_W = SUM_W + FRAC_BITS;
  localparam int CNT_W = $clog2(DVD_W + 1);
  localparam int QW    = gba_pkg::MEAN_W;

  logic [DVD_W-1:0]      dvd_q;
  logic [COUNT_BITS-1:0] dvs_q, rem_q;
  logic [QW-1:0]         quo_q;
  logic                  ovf_q, busy_q, done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [COUNT_BITS:0]   trial, diff;
  logic                  qbit;

  // remainder stays below the divisor, so it fits COUNT_BITS
  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign qbit  = (trial >= {1'b0, dvs_q});
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= DVD_W'(sum_i) << FRAC_BITS;
      dvs_q <= dvs_i;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      rem_q <= qbit ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
      // a one shifted out the top means the quotient exceeds 16 bits
      ovf_q <= ovf_q | quo_q[QW-1];
      quo_q <= {quo_q[QW-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quot_o = ovf_q ? '1 : quo_q;

endmodule

`default_nettype wire

// ----- hdl/gated_block_averager_core.sv -----
// Gated block averager: windowed accumulate, serial divide, result register.
// Depends on gba_pkg, gba_accum, gba_div.
//
// Samples inside the inclusive window [window_low, window_high] are summed and
// counted over block_length samples; the request that closes a block yields one
// result: the mean in unsigned Q10.6 (truncated, saturated at 65535), or the
// previous mean with held set when fewer than min_valid (or zero) samples were
// accepted. A closing sample that is not held goes through the bit-serial divider,
// which yields one quotient bit a cycle, and S_OUT then loads the result; a held
// block goes straight to S_OUT. No samples are taken in S_DIV or S_OUT. New
// samples are taken while a result waits on the output, until the next block
// closes.
`default_nettype none

module gated_block_averager_core #(
  parameter int SAMPLE_BITS = 10,
  parameter int COUNT_BITS  = 12,
  parameter int FRAC_BITS   = 6
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [gba_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [((SAMPLE_BITS > COUNT_BITS) ? SAMPLE_BITS : COUNT_BITS)-1:0]
                                                 cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [SAMPLE_BITS-1:0]            sample_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [gba_pkg::MEAN_W-1:0]             mean_q_o,
  output logic                                   held_o,
  output logic [COUNT_BITS-1:0]                  accepted_count_o
);

  localparam int CFG_W = (SAMPLE_BITS > COUNT_BITS) ? SAMPLE_BITS : COUNT_BITS;
  localparam int SUM_W = SAMPLE_BITS + COUNT_BITS;
  localparam int MW    = gba_pkg::MEAN_W;

  typedef enum logic [1:0] {S_IN, S_DIV, S_OUT} state_e;

  state_e                state_q;
  logic                  take;
  logic [SUM_W-1:0]      acc_sum;
  logic [COUNT_BITS-1:0] acc_cnt;
  gba_pkg::blk_ctrl_t    blk;
  logic                  div_start, div_done;
  logic [MW-1:0]         div_quot;
  logic [MW-1:0]         last_mean_q, res_mean_q, mean_q;
  logic                  res_held_q, held_q, out_valid_q;
  logic [COUNT_BITS-1:0] res_cnt_q, cnt_out_q;

  assign in_ready_o = (state_q == S_IN);
  assign take       = in_valid_i && in_ready_o;
  assign div_start  = blk.done && !blk.held;

  gba_accum #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS),
    .CFG_W       (CFG_W)
  ) u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .take_i     (take),
    .sample_i   (sample_i),
    .sum_o      (acc_sum),
    .acc_o      (acc_cnt),
    .ctrl_o     (blk)
  );

  gba_div #(
    .SUM_W      (SUM_W),
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (acc_sum),
    .dvs_i   (acc_cnt),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IN;
      out_valid_q <= 1'b0;
      last_mean_q <= '0;
      res_mean_q  <= '0;
      res_held_q  <= 1'b0;
      res_cnt_q   <= '0;
      mean_q      <= '0;
      held_q      <= 1'b0;
      cnt_out_q   <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IN: begin
          if (blk.done) begin
            res_held_q <= blk.held;
            res_cnt_q  <= acc_cnt;
            res_mean_q <= last_mean_q;
            state_q    <= blk.held ? S_OUT : S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            res_mean_q <= div_quot;
            state_q    <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            mean_q      <= res_mean_q;
            held_q      <= res_held_q;
            cnt_out_q   <= res_cnt_q;
            last_mean_q <= res_mean_q;
            state_q     <= S_IN;
          end
        end
        default: state_q <= S_IN;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign mean_q_o         = mean_q;
  assign held_o           = held_q;
  assign accepted_count_o = cnt_out_q;

endmodule

`default_nettype wire

// ----- tb/tb_gated_block_averager_core.sv -----
// Self-checking testbench for gated_block_averager_core: windowed block mean with hold.
// Depends on gba_pkg and the core RTL; a built-in predictor tracks sums, counts and last mean.
`default_nettype none

module tb_gated_block_averager_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W     = 10;
  localparam int COUNT_W      = 12;
  localparam int FRAC_W       = 6;
  localparam int CFG_W        = (SAMPLE_W > COUNT_W) ? SAMPLE_W : COUNT_W;
  localparam int SUM_W        = SAMPLE_W + COUNT_W;
  localparam int MEAN_W       = gba_pkg::MEAN_W;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_STALL   = 300;
  localparam int RANDOM_ITEMS = 1500;

  typedef struct packed {
    logic [MEAN_W-1:0]  mean_q;
    logic               held;
    logic [COUNT_W-1:0] accepted_count;
  } block_result_t;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                cfg_we     = 1'b0;
  logic [gba_pkg::CFG_IDX_W-1:0] cfg_idx = gba_pkg::REG_WIN_LO;
  logic [CFG_W-1:0]    cfg_data   = '0;
  logic                in_valid   = 1'b0;
  logic                in_ready_o;
  logic [SAMPLE_W-1:0] in_sample  = '0;
  logic                out_valid_o;
  logic                out_ready  = 1'b0;
  logic [MEAN_W-1:0]   mean_q_o;
  logic                held_o;
  logic [COUNT_W-1:0]  accepted_count_o;

  gated_block_averager_core #(
    .SAMPLE_BITS(SAMPLE_W),
    .COUNT_BITS (COUNT_W),
    .FRAC_BITS  (FRAC_W)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .sample_i        (in_sample),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .mean_q_o        (mean_q_o),
    .held_o          (held_o),
    .accepted_count_o(accepted_count_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Register mirror and accumulator state of the predictor
  logic [SAMPLE_W-1:0] win_lo_m  = SAMPLE_W'(gba_pkg::WIN_LO_RST);
  logic [SAMPLE_W-1:0] win_hi_m  = SAMPLE_W'(gba_pkg::WIN_HI_RST);
  logic [COUNT_W-1:0]  blk_len_m = COUNT_W'(gba_pkg::BLK_LEN_RST);
  logic [COUNT_W-1:0]  min_vld_m = COUNT_W'(gba_pkg::MIN_VLD_RST);
  logic [SUM_W-1:0]    acc_sum   = '0;
  logic [COUNT_W-1:0]  acc_cnt   = '0;
  logic [COUNT_W-1:0]  seen_cnt  = '0;
  logic [MEAN_W-1:0]   prev_mean = '0;

  block_result_t       expected_blocks[$];
  logic [SAMPLE_W-1:0] pending_samples[$];
  int unsigned samples_offered = 0;
  int unsigned samples_taken   = 0;
  int unsigned mismatches      = 0;
  int unsigned long_stall_reqs = 0;
  int unsigned long_stall_seen = 0;
  logic        in_taken        = 1'b0;
  logic        tx_idle_on      = 1'b1;
  logic        rx_idle_on      = 1'b1;
  int          tx_gap          = 0;
  int          rx_stall        = 0;

  // Update the running block with one accepted request; queue a result when it closes.
  task automatic absorb_sample(input logic [SAMPLE_W-1:0] s);
    logic [COUNT_W-1:0]      len;
    logic [SUM_W+FRAC_W-1:0] quo;
    logic                    hold;
    block_result_t           r;
    len = (blk_len_m == '0) ? COUNT_W'(1) : blk_len_m;
    if (s >= win_lo_m && s <= win_hi_m) begin
      acc_sum = acc_sum + SUM_W'(s);
      acc_cnt = acc_cnt + 1'b1;
    end
    seen_cnt = seen_cnt + 1'b1;
    if (seen_cnt >= len) begin
      hold = (acc_cnt == '0) || (acc_cnt < min_vld_m);
      if (!hold) begin
        quo = {acc_sum, {FRAC_W{1'b0}}} / acc_cnt;
        prev_mean = (quo > (SUM_W+FRAC_W)'(16'hFFFF)) ? 16'hFFFF : quo[MEAN_W-1:0];
      end
      r.mean_q         = prev_mean;
      r.held           = hold;
      r.accepted_count = acc_cnt;
      expected_blocks.push_back(r);
      acc_sum  = '0;
      acc_cnt  = '0;
      seen_cnt = '0;
    end
  endtask

  // Mostly no gap, some short, a few long
  function automatic int pick_gap(input logic idle_on);
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Bias toward the window edges and just outside them
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return win_lo_m;
      1: return win_hi_m;
      2: return win_lo_m - 1'b1;
      3: return win_hi_m + 1'b1;
      4, 5, 6: return SAMPLE_W'($urandom_range(win_hi_m, win_lo_m));
      7: return $urandom_range(0, 1) ? '1 : '0;
      default: return SAMPLE_W'($urandom_range(0, (1 << SAMPLE_W) - 1));
    endcase
  endfunction

  always @(negedge clk_i) begin : sender
    if (!in_valid || in_taken) begin
      if (tx_gap > 0) begin
        tx_gap   <= tx_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        in_valid  <= 1'b1;
        in_sample <= pending_samples.pop_front();
        tx_gap    <= pick_gap(tx_idle_on);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : receiver
    int g;
    if (long_stall_reqs != long_stall_seen) begin
      long_stall_seen <= long_stall_seen + 1;
      rx_stall        <= LONG_STALL;
      out_ready       <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall  <= rx_stall - 1;
      out_ready <= 1'b0;
    end else begin
      g = pick_gap(rx_idle_on);
      if (g > 0) begin
        rx_stall  <= g - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    block_result_t want;
    in_taken <= in_valid && in_ready_o;
    if (rst_ni) begin
      // Check before absorbing so a same-edge push cannot hide an extra result
      if (out_valid_o && out_ready) begin
        if (expected_blocks.size() == 0) begin
          $display("%0t: unexpected result mean_q=%0d held=%0d count=%0d", $time,
                   mean_q_o, held_o, accepted_count_o);
          mismatches++;
        end else begin
          want = expected_blocks.pop_front();
          if (mean_q_o !== want.mean_q) begin
            $display("%0t: mean_q expected %0d actual %0d", $time, want.mean_q, mean_q_o);
            mismatches++;
          end
          if (held_o !== want.held) begin
            $display("%0t: held expected %0d actual %0d", $time, want.held, held_o);
            mismatches++;
          end
          if (accepted_count_o !== want.accepted_count) begin
            $display("%0t: accepted_count expected %0d actual %0d", $time,
                     want.accepted_count, accepted_count_o);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready_o) begin
        absorb_sample(in_sample);
        samples_taken <= samples_taken + 1;
      end
    end
  end

  task automatic offer(input logic [SAMPLE_W-1:0] s);
    pending_samples.push_back(s);
    samples_offered++;
  endtask

  task automatic set_reg(input logic [gba_pkg::CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_W'(value);
    case (idx)
      gba_pkg::REG_WIN_LO:  win_lo_m  = SAMPLE_W'(value);
      gba_pkg::REG_WIN_HI:  win_hi_m  = SAMPLE_W'(value);
      gba_pkg::REG_BLK_LEN: blk_len_m = COUNT_W'(value);
      gba_pkg::REG_MIN_VLD: min_vld_m = COUNT_W'(value);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Every request taken, every result seen, then let a trailing close finish
  task automatic wait_drained();
    while (samples_taken != samples_offered || expected_blocks.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic random_config();
    int unsigned lo, hi, len;
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) begin
      lo = 0;
      hi = (1 << SAMPLE_W) - 1;
    end else if (r < 3) begin
      hi = $urandom_range(0, (1 << SAMPLE_W) - 2);
      lo = $urandom_range(hi + 1, (1 << SAMPLE_W) - 1);
    end else if (r < 4) begin
      lo = $urandom_range(0, 2) == 0 ? 0 : ($urandom_range(0, 1) ? (1 << SAMPLE_W) - 1
                                              : $urandom_range(0, (1 << SAMPLE_W) - 1));
      hi = lo;
    end else begin
      lo = $urandom_range(0, (1 << SAMPLE_W) - 1);
      hi = $urandom_range(lo, (1 << SAMPLE_W) - 1);
    end
    if ($urandom_range(0, 4) != 0) set_reg(gba_pkg::REG_WIN_LO, lo);
    if ($urandom_range(0, 4) != 0) set_reg(gba_pkg::REG_WIN_HI, hi);
    r = $urandom_range(0, 99);
    if (r < 10)      len = 0;
    else if (r < 75) len = $urandom_range(1, 6);
    else if (r < 95) len = $urandom_range(7, 40);
    else             len = $urandom_range(41, 200);
    if ($urandom_range(0, 3) != 0) set_reg(gba_pkg::REG_BLK_LEN, len);
    len = (blk_len_m == 0) ? 1 : blk_len_m;
    r = $urandom_range(0, 9);
    if ($urandom_range(0, 2) != 0) begin
      if (r < 3)      set_reg(gba_pkg::REG_MIN_VLD, 0);
      else if (r < 8) set_reg(gba_pkg::REG_MIN_VLD, $urandom_range(0, len));
      else if (r < 9) set_reg(gba_pkg::REG_MIN_VLD, (1 << COUNT_W) - 1);
      else set_reg(gba_pkg::REG_MIN_VLD, $urandom_range(len + 1, (1 << COUNT_W) - 1));
    end
  endtask

  initial begin : stimulus
    int unsigned n;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings, then shorten the block past the count already reached
    offer(509); offer(974); offer(508);
    wait_drained();
    set_reg(gba_pkg::REG_BLK_LEN, 2);
    offer(975);
    wait_drained();

    // Full window, fresh mean at the sample extremes
    set_reg(gba_pkg::REG_WIN_LO, 0);
    set_reg(gba_pkg::REG_WIN_HI, 1023);
    set_reg(gba_pkg::REG_BLK_LEN, 4);
    set_reg(gba_pkg::REG_MIN_VLD, 0);
    repeat (4) offer(1023);
    repeat (4) offer(0);
    offer(0); offer(1023); offer(1); offer(1022);
    wait_drained();

    // Inverted window and zero block length: every block empty and held
    set_reg(gba_pkg::REG_WIN_LO, 600);
    set_reg(gba_pkg::REG_WIN_HI, 500);
    set_reg(gba_pkg::REG_BLK_LEN, 0);
    offer(550); offer(1023);
    wait_drained();

    // Longest block and largest min_valid, then cut short: held on count
    set_reg(gba_pkg::REG_WIN_LO, 0);
    set_reg(gba_pkg::REG_WIN_HI, 1023);
    set_reg(gba_pkg::REG_BLK_LEN, 4095);
    set_reg(gba_pkg::REG_MIN_VLD, 4095);
    repeat (5) offer(SAMPLE_W'($urandom_range(0, 1023)));
    wait_drained();
    set_reg(gba_pkg::REG_BLK_LEN, 3);
    offer(7);
    wait_drained();

    // Output held off for a long stretch while requests keep coming
    set_reg(gba_pkg::REG_BLK_LEN, 1);
    set_reg(gba_pkg::REG_MIN_VLD, 0);
    tx_idle_on = 1'b0;
    repeat (60) offer(pick_sample());
    long_stall_reqs++;
    wait_drained();

    n = 0;
    while (n < RANDOM_ITEMS) begin
      random_config();
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(20, 80)) begin
        offer(pick_sample());
        n++;
      end
      wait_drained();
    end

    if (mismatches == 0)
      $display("gated_block_averager_core regression: pass");
    else
      $display("gated_block_averager_core regression: fail");
    $finish;
  end

  initial begin : watchdog
    #(10_000_000);
    $display("gated_block_averager_core regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
